[hw/rtl/snu_pkg.sv]
// Shared constants for the surface normal unit: command and shape codes,
// and the fixed widths of the normalizing datapath. No dependencies.
package snu_pkg;

   localparam logic [2:0] CMD_POINT   = 3'd0;
   localparam logic [2:0] CMD_CENTER  = 3'd1;
   localparam logic [2:0] CMD_AXIS    = 3'd2;
   localparam logic [2:0] CMD_RAY_A   = 3'd3;
   localparam logic [2:0] CMD_RAY_B   = 3'd4;
   localparam logic [2:0] CMD_DIST    = 3'd5;
   localparam logic [2:0] CMD_COMPUTE = 3'd6;

   localparam logic [1:0] SHAPE_SPHERE   = 2'd0;
   localparam logic [1:0] SHAPE_PLANE    = 2'd1;
   localparam logic [1:0] SHAPE_CYLINDER = 2'd2;

   // Output normals are signed Q1.16.
   localparam int NRM_W    = 18;
   localparam int OUT_FRAC = 16;
   localparam int ONE_OUT  = 65536;

   // Scaled magnitudes stay below 2^30, so the sum of squares needs 62 bits,
   // its root 31 bits, the divide numerator 47 bits and the quotient 17 bits.
   localparam int SQ_W   = 62;
   localparam int ROOT_W = 31;
   localparam int NUM_W  = 47;
   localparam int QUO_W  = 17;

endpackage

[hw/rtl/surface_normal_unit.sv]
// Surface normal unit top level: request decode, vector registers and the
// sequencer driving the shared multiplier, square root and divider.
// Depends on snu_pkg, snu_mul, snu_sqrt and snu_div.
//
// Usage. Each request carries a command, a shape and three Q16.16 values.
// Load commands write the hit point, the centre or base point, the axis,
// the two ray terms or the hit distance; they give no
// response. A compute request yields one response with a Q1.16 normal, a
// cylinder flag and a degenerate flag. Unknown commands and shapes are
// dropped without a response.
// Timing. Every product goes through the one shared multiplier, magnitude
// scaling moves one bit per cycle (up to 29 shifts), the square root
// resolves one bit per cycle, and the three divides run one after another.
// req_stall is high from the acceptance of a compute request until its
// response is registered.
// Stalls. A finished response waits in the output register while
// rsp_stall is high; loads are still taken meanwhile, but a new compute
// holds in its last state until the output register is free.
// Reset. Synchronous reset clears every stored vector to zero and drops
// any response in flight.
module surface_normal_unit import snu_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_command,
   input  logic [1:0]              req_shape,
   input  logic signed [31:0]      req_value_x,
   input  logic signed [31:0]      req_value_y,
   input  logic signed [31:0]      req_value_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [NRM_W-1:0] rsp_normal_x,
   output logic signed [NRM_W-1:0] rsp_normal_y,
   output logic signed [NRM_W-1:0] rsp_normal_z,
   output logic                    rsp_from_cylinder,
   output logic                    rsp_degenerate
);

   localparam int CW = COORD_WIDTH;
   // Multiplier operands must hold a coordinate and a 30-bit scaled magnitude.
   localparam int MW = (CW > 31) ? CW : 31;
   localparam int XW = 2 * MW + 2;
   localparam int LW = (CW < 32) ? CW : 32;
   localparam int SH_R = (FRAC_BITS >= OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
   localparam int SH_L = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
   localparam logic signed [XW-1:0] ONE_X  = XW'(1);
   localparam logic signed [XW-1:0] CMAX_X = (ONE_X <<< (CW - 1)) - ONE_X;
   localparam logic signed [XW-1:0] CMIN_X = -CMAX_X - ONE_X;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DOTA, ST_DOTB, ST_MVAL, ST_VEC, ST_NMAX, ST_NSHIFT,
      ST_SQR, ST_ROOT, ST_DIV, ST_PLANE, ST_OUT
   } state_type;

   // Clamp a wide intermediate to the signed coordinate range.
   function automatic logic signed [CW-1:0] sat_cw(input logic signed [XW-1:0] v);
      logic signed [CW-1:0] r;
      if (v > CMAX_X) r = CW'(CMAX_X);
      else if (v < CMIN_X) r = CW'(CMIN_X);
      else r = v[CW-1:0];
      return r;
   endfunction

   // Plane axis component to Q1.16, rounding toward minus infinity, clamped.
   function automatic logic signed [NRM_W-1:0] to_out(input logic signed [CW-1:0] v);
      logic signed [63:0] t;
      logic signed [NRM_W-1:0] r;
      t = (64'(v) <<< SH_L) >>> SH_R;
      if (t > 64'(ONE_OUT)) r = NRM_W'(ONE_OUT);
      else if (t < -64'(ONE_OUT)) r = -NRM_W'(ONE_OUT);
      else r = t[NRM_W-1:0];
      return r;
   endfunction

   state_type state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic       ph_ff, ph_in;
   logic       cyl_ff, cyl_in;
   logic       deg_ff, deg_in;

   logic signed [CW-1:0] hp_ff [0:2], hp_in [0:2];
   logic signed [CW-1:0] oc_ff [0:2], oc_in [0:2];
   logic signed [CW-1:0] ax_ff [0:2], ax_in [0:2];
   logic signed [CW-1:0] ra_ff [0:2], ra_in [0:2];
   logic signed [CW-1:0] rb_ff [0:2], rb_in [0:2];
   logic signed [CW-1:0] hd_ff, hd_in;

   logic signed [CW+1:0] acc_ff, acc_in;
   logic signed [CW-1:0] dota_ff, dota_in;
   logic signed [CW-1:0] m_ff, m_in;
   logic signed [CW-1:0] v_ff [0:2], v_in [0:2];
   logic [MW-1:0]        w_ff [0:2], w_in [0:2];
   logic [MW-1:0]        mx_ff, mx_in;
   logic [SQ_W-1:0]      s_ff, s_in;
   logic [ROOT_W-1:0]    len_ff, len_in;
   logic signed [NRM_W-1:0] n_ff [0:2], n_in [0:2];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [NRM_W-1:0] rsp_nx_ff, rsp_nx_in;
   logic signed [NRM_W-1:0] rsp_ny_ff, rsp_ny_in;
   logic signed [NRM_W-1:0] rsp_nz_ff, rsp_nz_in;
   logic                    rsp_cyl_ff, rsp_cyl_in;
   logic                    rsp_deg_ff, rsp_deg_in;

   logic signed [MW-1:0]   mul_a, mul_b;
   logic signed [2*MW-1:0] prod;
   logic signed [2*MW-1:0] psh;
   logic signed [CW-1:0]   fm;
   logic                   root_start, root_done;
   logic [ROOT_W-1:0]      root;
   logic                   div_start, div_done;
   logic [NUM_W-1:0]       div_num;
   logic [QUO_W-1:0]       quo;
   logic signed [LW-1:0]   ld_x, ld_y, ld_z;

   snu_mul #(.AW(MW)) u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   snu_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .rad   (s_in),
      .done  (root_done),
      .root  (root)
   );

   snu_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (len_ff),
      .done  (div_done),
      .quo   (quo)
   );

   // Fixed-point product: floor shift, then saturation to the coordinate range.
   assign psh = prod >>> FRAC_BITS;
   assign fm  = sat_cw(XW'(psh));

   assign ld_x = req_value_x[LW-1:0];
   assign ld_y = req_value_y[LW-1:0];
   assign ld_z = req_value_z[LW-1:0];

   assign div_num = {w_ff[idx_ff][29:0], 16'd0} + NUM_W'(len_ff >> 1);

   // The shared multiplier's operands follow the sequencer state.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_DOTA: begin
            mul_a = MW'(ra_ff[idx_ff]);
            mul_b = MW'(ax_ff[idx_ff]);
         end
         ST_DOTB: begin
            mul_a = MW'(rb_ff[idx_ff]);
            mul_b = MW'(ax_ff[idx_ff]);
         end
         ST_MVAL: begin
            mul_a = MW'(dota_ff);
            mul_b = MW'(hd_ff);
         end
         ST_VEC: begin
            mul_a = MW'(ax_ff[idx_ff]);
            mul_b = MW'(m_ff);
         end
         ST_SQR: begin
            mul_a = signed'(w_ff[idx_ff]);
            mul_b = signed'(w_ff[idx_ff]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      logic signed [CW+1:0] sum;
      logic signed [CW-1:0] dif;
      logic signed [CW-1:0] vv;
      logic signed [XW-1:0] av;
      logic [MW-1:0]        mx;

      state_in = state_ff;
      idx_in   = idx_ff;
      ph_in    = ph_ff;
      cyl_in   = cyl_ff;
      deg_in   = deg_ff;
      hp_in    = hp_ff;
      oc_in    = oc_ff;
      ax_in    = ax_ff;
      ra_in    = ra_ff;
      rb_in    = rb_ff;
      hd_in    = hd_ff;
      acc_in   = acc_ff;
      dota_in  = dota_ff;
      m_in     = m_ff;
      v_in     = v_ff;
      w_in     = w_ff;
      mx_in    = mx_ff;
      s_in     = s_ff;
      len_in   = len_ff;
      n_in     = n_ff;
      root_start = 1'b0;
      div_start  = 1'b0;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_nx_in  = rsp_nx_ff;
      rsp_ny_in  = rsp_ny_ff;
      rsp_nz_in  = rsp_nz_ff;
      rsp_cyl_in = rsp_cyl_ff;
      rsp_deg_in = rsp_deg_ff;

      sum = acc_ff + (CW+2)'(fm);
      dif = sat_cw(XW'(hp_ff[idx_ff]) - XW'(oc_ff[idx_ff]));
      vv  = sat_cw(XW'(dif) - XW'(fm));
      av  = (vv < 0) ? -XW'(vv) : XW'(vv);
      mx  = w_ff[0];
      if (w_ff[1] > mx) mx = w_ff[1];
      if (w_ff[2] > mx) mx = w_ff[2];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in = 2'd0;
               ph_in  = 1'b0;
               acc_in = '0;
               case (req_command)
                  CMD_POINT: begin
                     hp_in[0] = CW'(ld_x);
                     hp_in[1] = CW'(ld_y);
                     hp_in[2] = CW'(ld_z);
                  end
                  CMD_CENTER: begin
                     oc_in[0] = CW'(ld_x);
                     oc_in[1] = CW'(ld_y);
                     oc_in[2] = CW'(ld_z);
                  end
                  CMD_AXIS: begin
                     ax_in[0] = CW'(ld_x);
                     ax_in[1] = CW'(ld_y);
                     ax_in[2] = CW'(ld_z);
                  end
                  CMD_RAY_A: begin
                     ra_in[0] = CW'(ld_x);
                     ra_in[1] = CW'(ld_y);
                     ra_in[2] = CW'(ld_z);
                  end
                  CMD_RAY_B: begin
                     rb_in[0] = CW'(ld_x);
                     rb_in[1] = CW'(ld_y);
                     rb_in[2] = CW'(ld_z);
                  end
                  CMD_DIST: begin
                     hd_in = CW'(ld_x);
                  end
                  CMD_COMPUTE: begin
                     deg_in = 1'b0;
                     case (req_shape)
                        SHAPE_SPHERE: begin
                           // A zero scale factor turns the cylinder step into
                           // the plain point minus centre difference.
                           cyl_in   = 1'b0;
                           m_in     = '0;
                           state_in = ST_VEC;
                        end
                        SHAPE_PLANE: begin
                           cyl_in   = 1'b0;
                           state_in = ST_PLANE;
                        end
                        SHAPE_CYLINDER: begin
                           cyl_in   = 1'b1;
                           state_in = ST_DOTA;
                        end
                        default: begin
                           state_in = ST_IDLE;
                        end
                     endcase
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DOTA, ST_DOTB: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               acc_in = sum;
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd2) begin
                  acc_in = '0;
                  idx_in = 2'd0;
                  if (state_ff == ST_DOTA) begin
                     dota_in  = sat_cw(XW'(sum));
                     state_in = ST_DOTB;
                  end else begin
                     // The second dot product waits in m until it is added.
                     m_in     = sat_cw(XW'(sum));
                     state_in = ST_MVAL;
                  end
               end
            end
         end
         ST_MVAL: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               m_in     = sat_cw(XW'(fm) + XW'(m_ff));
               idx_in   = 2'd0;
               state_in = ST_VEC;
            end
         end
         ST_VEC: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               v_in[idx_ff] = vv;
               w_in[idx_ff] = av[MW-1:0];
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd2) begin
                  idx_in   = 2'd0;
                  state_in = ST_NMAX;
               end
            end
         end
         ST_NMAX: begin
            mx_in = mx;
            if (mx == '0) begin
               deg_in   = 1'b1;
               n_in[0]  = '0;
               n_in[1]  = '0;
               n_in[2]  = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_NSHIFT;
            end
         end
         ST_NSHIFT: begin
            // Scale all magnitudes together until the largest is in [2^29, 2^30).
            if (mx_ff[MW-1:30] != '0) begin
               mx_in   = mx_ff >> 1;
               w_in[0] = w_ff[0] >> 1;
               w_in[1] = w_ff[1] >> 1;
               w_in[2] = w_ff[2] >> 1;
            end else if (!mx_ff[29]) begin
               mx_in   = mx_ff << 1;
               w_in[0] = w_ff[0] << 1;
               w_in[1] = w_ff[1] << 1;
               w_in[2] = w_ff[2] << 1;
            end else begin
               s_in     = '0;
               idx_in   = 2'd0;
               ph_in    = 1'b0;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               s_in   = s_ff + prod[SQ_W-1:0];
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd2) begin
                  root_start = 1'b1;
                  idx_in     = 2'd0;
                  state_in   = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               len_in   = root;
               ph_in    = 1'b0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!ph_ff) begin
               div_start = 1'b1;
               ph_in     = 1'b1;
            end else if (div_done) begin
               n_in[idx_ff] = v_ff[idx_ff][CW-1] ? -NRM_W'(quo) : NRM_W'(quo);
               ph_in  = 1'b0;
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd2) begin
                  idx_in   = 2'd0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_PLANE: begin
            n_in[0]  = to_out(ax_ff[0]);
            n_in[1]  = to_out(ax_ff[1]);
            n_in[2]  = to_out(ax_ff[2]);
            deg_in   = (ax_ff[0] == '0) && (ax_ff[1] == '0) && (ax_ff[2] == '0);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_nx_in    = n_ff[0];
               rsp_ny_in    = n_ff[1];
               rsp_nz_in    = n_ff[2];
               rsp_cyl_in   = cyl_ff;
               rsp_deg_in   = deg_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            hp_ff[i] <= '0;
            oc_ff[i] <= '0;
            ax_ff[i] <= '0;
            ra_ff[i] <= '0;
            rb_ff[i] <= '0;
         end
         hd_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hp_ff <= hp_in;
         oc_ff <= oc_in;
         ax_ff <= ax_in;
         ra_ff <= ra_in;
         rb_ff <= rb_in;
         hd_ff <= hd_in;
      end
      idx_ff     <= idx_in;
      ph_ff      <= ph_in;
      cyl_ff     <= cyl_in;
      deg_ff     <= deg_in;
      acc_ff     <= acc_in;
      dota_ff    <= dota_in;
      m_ff       <= m_in;
      v_ff       <= v_in;
      w_ff       <= w_in;
      mx_ff      <= mx_in;
      s_ff       <= s_in;
      len_ff     <= len_in;
      n_ff       <= n_in;
      rsp_nx_ff  <= rsp_nx_in;
      rsp_ny_ff  <= rsp_ny_in;
      rsp_nz_ff  <= rsp_nz_in;
      rsp_cyl_ff <= rsp_cyl_in;
      rsp_deg_ff <= rsp_deg_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_normal_x      = rsp_nx_ff;
   assign rsp_normal_y      = rsp_ny_ff;
   assign rsp_normal_z      = rsp_nz_ff;
   assign rsp_from_cylinder = rsp_cyl_ff;
   assign rsp_degenerate    = rsp_deg_ff;

`ifndef SYNTHESIS
   // A compute request with a known shape always starts the sequencer.
   a_compute_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command == CMD_COMPUTE &&
       (req_shape == SHAPE_SPHERE || req_shape == SHAPE_PLANE ||
        req_shape == SHAPE_CYLINDER)) |=> state_ff != ST_IDLE)
      else $error("compute request did not start the sequencer");

   // A degenerate response carries an all-zero normal.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
      (rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0))
      else $error("degenerate response with nonzero normal");

   // Every normal component stays within plus or minus one.
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
      (rsp_normal_x <= NRM_W'(ONE_OUT) && rsp_normal_x >= -NRM_W'(ONE_OUT) &&
       rsp_normal_y <= NRM_W'(ONE_OUT) && rsp_normal_y >= -NRM_W'(ONE_OUT) &&
       rsp_normal_z <= NRM_W'(ONE_OUT) && rsp_normal_z >= -NRM_W'(ONE_OUT)))
      else $error("normal component out of range");

   // The root finishes only while the sequencer waits for it.
   a_root_done: assert property (@(posedge clock) disable iff (reset)
      root_done |-> state_ff == ST_ROOT)
      else $error("square root finished outside its wait state");
`endif

endmodule

[hw/rtl/snu_mul.sv]
// Registered signed multiplier shared by every product of the normal unit.
// Depends on nothing.
module snu_mul #(
   parameter int AW = 32
) (
   input  logic                   clock,
   input  logic signed [AW-1:0]   mul_a,
   input  logic signed [AW-1:0]   mul_b,
   output logic signed [2*AW-1:0] prod
);

   logic signed [2*AW-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;

endmodule

[hw/rtl/snu_sqrt.sv]
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on snu_pkg for the radicand and root widths.
module snu_sqrt import snu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   rad,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  k_ff;
   logic [63:0] s_ff;
   logic [63:0] r_ff;
   logic [63:0] bitv;
   logic [63:0] trial;

   assign bitv  = 64'(1) << {k_ff, 1'b0};
   assign trial = r_ff + bitv;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && k_ff == 5'd0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         s_ff <= 64'(rad);
         r_ff <= 64'd0;
         k_ff <= 5'd31;
      end else if (busy_ff) begin
         if (s_ff >= trial) begin
            s_ff <= s_ff - trial;
            r_ff <= (r_ff >> 1) + bitv;
         end else begin
            r_ff <= r_ff >> 1;
         end
         k_ff <= k_ff - 5'd1;
      end
   end

   assign done = done_ff;
   assign root = r_ff[ROOT_W-1:0];

endmodule

[hw/rtl/snu_div.sv]
// Restoring divider, one quotient bit per cycle, for quotients below 2^17.
// Depends on snu_pkg for the operand widths.
module snu_div import snu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [ROOT_W-1:0] den,
   output logic              done,
   output logic [QUO_W-1:0]  quo
);

   logic              busy_ff;
   logic              done_ff;
   logic [4:0]        cnt_ff;
   logic [ROOT_W:0]   rem_ff;
   logic [QUO_W-1:0]  lo_ff;
   logic [QUO_W-1:0]  q_ff;
   logic [ROOT_W-1:0] den_ff;
   logic [ROOT_W:0]   r2;
   logic              ge;

   assign r2 = {rem_ff[ROOT_W-1:0], lo_ff[QUO_W-1]};
   assign ge = r2 >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 5'd0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= (ROOT_W+1)'(num[NUM_W-1:QUO_W]);
         lo_ff  <= num[QUO_W-1:0];
         den_ff <= den;
         q_ff   <= '0;
         cnt_ff <= 5'(QUO_W - 1);
      end else if (busy_ff) begin
         rem_ff <= ge ? r2 - {1'b0, den_ff} : r2;
         q_ff   <= {q_ff[QUO_W-2:0], ge};
         lo_ff  <= lo_ff << 1;
         cnt_ff <= cnt_ff - 5'd1;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

[tb/sv/surface_normal_checker.sv]
// Scoreboard for the surface normal unit: watches both channels, keeps its own copy of the
// vector registers, predicts every compute response and compares it field by field.
// Depends on snu_pkg for command, shape and width constants.
module surface_normal_checker import snu_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [2:0]              req_command,
   input  logic [1:0]              req_shape,
   input  logic signed [31:0]      req_value_x,
   input  logic signed [31:0]      req_value_y,
   input  logic signed [31:0]      req_value_z,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic signed [NRM_W-1:0] rsp_normal_x,
   input  logic signed [NRM_W-1:0] rsp_normal_y,
   input  logic signed [NRM_W-1:0] rsp_normal_z,
   input  logic                    rsp_from_cylinder,
   input  logic                    rsp_degenerate,
   output int                      pending,
   output int                      fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CMAX = 64'sd2147483647;
   localparam longint CMIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [NRM_W-1:0] nx;
      logic signed [NRM_W-1:0] ny;
      logic signed [NRM_W-1:0] nz;
      logic                    cyl;
      logic                    degen;
   } normal_type;

   longint  point_r[3], center_r[3], axis_r[3], ray_a_r[3], ray_b_r[3];
   longint  dist_r;
   normal_type normals_due[$];

   function automatic longint clamp_coord(longint v);
      if (v > CMAX) return CMAX;
      if (v < CMIN) return CMIN;
      return v;
   endfunction

   // Q16.16 product, floor rounding, saturated.
   function automatic longint fixed_mul(longint a, longint b);
      longint unsigned ua, ub, p, q;
      logic neg;
      ua  = (a < 0) ? -a : a;
      ub  = (b < 0) ? -b : b;
      neg = (a < 0) != (b < 0);
      p   = ua * ub;
      q   = p >> 16;
      if (neg && p[15:0] != 0) q++;
      if (!neg) return (q > CMAX) ? CMAX : longint'(q);
      if (q > longint'(CMAX) + 1) return CMIN;
      return -longint'(q);
   endfunction

   function automatic longint dot_axis(longint x[3]);
      return clamp_coord(fixed_mul(x[0], axis_r[0]) + fixed_mul(x[1], axis_r[1])
                         + fixed_mul(x[2], axis_r[2]));
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic normal_type unit_vector(longint v[3]);
      longint unsigned w[3], m, s, len, q;
      longint  n[3];
      normal_type res;
      res = '0;
      for (int i = 0; i < 3; i++) w[i] = (v[i] < 0) ? -v[i] : v[i];
      m = w[0];
      if (w[1] > m) m = w[1];
      if (w[2] > m) m = w[2];
      if (m == 0) begin
         res.degen = 1'b1;
         return res;
      end
      while (m >= (64'd1 << 30)) begin
         m >>= 1;
         for (int i = 0; i < 3; i++) w[i] >>= 1;
      end
      while (m < (64'd1 << 29)) begin
         m <<= 1;
         for (int i = 0; i < 3; i++) w[i] <<= 1;
      end
      s   = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
      len = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         q    = (w[i] * ONE_OUT + len / 2) / len;
         n[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
      res.nx = n[0];
      res.ny = n[1];
      res.nz = n[2];
      return res;
   endfunction

   function automatic longint clamp_unit(longint v);
      if (v > ONE_OUT) return ONE_OUT;
      if (v < -ONE_OUT) return -ONE_OUT;
      return v;
   endfunction

   always @(posedge clock) begin
      longint  vals[3], v[3], m;
      normal_type e, got;
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            point_r[i] = 0; center_r[i] = 0; axis_r[i] = 0;
            ray_a_r[i] = 0; ray_b_r[i] = 0;
         end
         dist_r = 0;
         normals_due.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_normal_x, rsp_normal_y, rsp_normal_z,
                    rsp_from_cylinder, rsp_degenerate};
            if (normals_due.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response: %p", got);
               fail_count <= fail_count + 1;
            end else begin
               e = normals_due.pop_front();
               if (got !== e) begin
                  if (fail_count < 10)
                     $display("normal wrong: expected %p, got %p", e, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            vals[0] = req_value_x;
            vals[1] = req_value_y;
            vals[2] = req_value_z;
            case (req_command)
               CMD_POINT:   point_r  = vals;
               CMD_CENTER:  center_r = vals;
               CMD_AXIS:    axis_r   = vals;
               CMD_RAY_A:   ray_a_r  = vals;
               CMD_RAY_B:   ray_b_r  = vals;
               CMD_DIST:    dist_r   = vals[0];
               CMD_COMPUTE: begin
                  case (req_shape)
                     SHAPE_SPHERE: begin
                        for (int i = 0; i < 3; i++)
                           v[i] = clamp_coord(point_r[i] - center_r[i]);
                        normals_due.push_back(unit_vector(v));
                     end
                     SHAPE_PLANE: begin
                        e.nx    = clamp_unit(axis_r[0]);
                        e.ny    = clamp_unit(axis_r[1]);
                        e.nz    = clamp_unit(axis_r[2]);
                        e.cyl   = 1'b0;
                        e.degen = (axis_r[0] == 0 && axis_r[1] == 0 && axis_r[2] == 0);
                        normals_due.push_back(e);
                     end
                     SHAPE_CYLINDER: begin
                        // Axial coordinate of the hit, then the radial remainder.
                        m = clamp_coord(fixed_mul(dot_axis(ray_a_r), dist_r)
                                        + dot_axis(ray_b_r));
                        for (int i = 0; i < 3; i++)
                           v[i] = clamp_coord(clamp_coord(point_r[i] - center_r[i])
                                              - fixed_mul(axis_r[i], m));
                        e = unit_vector(v);
                        e.cyl = 1'b1;
                        normals_due.push_back(e);
                     end
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end
      end
      pending <= normals_due.size();
   end

endmodule

[tb/sv/testbench.sv]
// Top of the surface normal unit testbench: clock, reset, request stimulus under several
// idle and stall mixes, and the final verdict. Depends on snu_pkg, the unit and
// surface_normal_checker.
module testbench;
   import snu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Codes the unit must drop without a response.
   localparam logic [2:0] CMD_UNKNOWN   = 3'd7;
   localparam logic [1:0] SHAPE_UNKNOWN = 2'd3;
   localparam int         RANDOM_ITEMS  = 2000;
   localparam longint     CYCLE_LIMIT   = 3000000;

   logic                    clock, reset;
   logic                    req_valid, req_stall;
   logic [2:0]              req_command;
   logic [1:0]              req_shape;
   logic signed [31:0]      req_value_x, req_value_y, req_value_z;
   logic                    rsp_valid, rsp_stall;
   logic signed [NRM_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic                    rsp_from_cylinder, rsp_degenerate;
   int                      pending, fail_count;
   int                      idle_pct, stall_pct;
   longint                  cycles;

   surface_normal_unit DUT (.*);
   surface_normal_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Timeout: a hung handshake ends the run as a failure.
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("surface_normal_unit: mismatch");
         $finish;
      end
   end

   // The response side stalls at random according to the current phase.
   initial rsp_stall = 1'b0;
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // Coordinates are small half of the time so that normals are well spread, with some full-range
   // values to hit saturation, the most negative value and all-zero components.
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return 0;
         3, 4:    return $urandom();
         default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      endcase
   endfunction

   // Present one request and hold it until the unit takes it. Sender idling is decided
   // at each falling edge before the request goes out.
   task automatic send_request(logic [2:0] cmd, logic [1:0] shp,
                               logic [31:0] x, logic [31:0] y, logic [31:0] z);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         req_command <= 3'($urandom());
         req_value_x <= $urandom();
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_shape   <= shp;
      req_value_x <= x;
      req_value_y <= y;
      req_value_z <= z;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random_coords(logic [2:0] cmd, logic [1:0] shp);
      send_request(cmd, shp, pick_coord(), pick_coord(), pick_coord());
   endtask

   initial begin
      int sent;
      int phase;
      idle_pct    = 0;
      stall_pct   = 0;
      req_valid   = 1'b0;
      req_command = CMD_POINT;
      req_shape   = SHAPE_SPHERE;
      req_value_x = 0;
      req_value_y = 0;
      req_value_z = 0;
      reset       = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. Computing from the reset state gives degenerate sphere, plane and
      // cylinder normals.
      send_request(CMD_COMPUTE, SHAPE_SPHERE, 0, 0, 0);
      send_request(CMD_COMPUTE, SHAPE_PLANE, 0, 0, 0);
      send_request(CMD_COMPUTE, SHAPE_CYLINDER, 0, 0, 0);
      // Extreme point against an opposite-extreme centre saturates the difference.
      send_request(CMD_POINT, SHAPE_SPHERE, 32'sh7fff_ffff, 32'sh8000_0000, 32'h0001_0000);
      send_request(CMD_CENTER, SHAPE_SPHERE, 32'sh8000_0000, 32'sh7fff_ffff, 0);
      send_request(CMD_COMPUTE, SHAPE_SPHERE, 0, 0, 0);
      // Plane axis beyond one unit is clamped, negative too.
      send_request(CMD_AXIS, SHAPE_PLANE, 32'h0002_0000, 32'hfffe_0000, 32'h0000_8000);
      send_request(CMD_COMPUTE, SHAPE_PLANE, 0, 0, 0);
      // A simple unit cylinder along z.
      send_request(CMD_POINT, SHAPE_SPHERE, 32'h0001_0000, 0, 32'h0003_0000);
      send_request(CMD_CENTER, SHAPE_SPHERE, 0, 0, 0);
      send_request(CMD_AXIS, SHAPE_SPHERE, 0, 0, 32'h0001_0000);
      send_request(CMD_RAY_A, SHAPE_SPHERE, 0, 0, 32'h0001_0000);
      send_request(CMD_RAY_B, SHAPE_SPHERE, 0, 0, 32'h0001_0000);
      send_request(CMD_DIST, SHAPE_SPHERE, 32'h0002_0000, 32'hffff_ffff, 32'hffff_ffff);
      send_request(CMD_COMPUTE, SHAPE_CYLINDER, 0, 0, 0);
      // Huge ray terms and distance drive the scaled dot product into saturation.
      send_request(CMD_RAY_A, SHAPE_SPHERE, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
      send_request(CMD_DIST, SHAPE_SPHERE, 32'sh8000_0000, 0, 0);
      send_request(CMD_COMPUTE, SHAPE_CYLINDER, 0, 0, 0);
      // Unknown command and unknown shape are dropped.
      send_request(CMD_UNKNOWN, SHAPE_SPHERE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_request(CMD_COMPUTE, SHAPE_UNKNOWN, 0, 0, 0);
      send_request(CMD_COMPUTE, SHAPE_SPHERE, 0, 0, 0);

      // Random part in phases: no idling, sender idle, receiver stalling, both.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         phase = (sent * 5) / RANDOM_ITEMS;
         idle_pct  = (phase == 1) ? 51 : (phase >= 3) ? 21 : 0;
         stall_pct = (phase == 2) ? 51 : (phase >= 3) ? 21 : 0;
         if ($urandom_range(99) < 80) begin
            // A well-formed burst: a few register loads and then a compute.
            for (int c = CMD_POINT; c <= CMD_DIST; c++)
               if ($urandom_range(99) < 50) begin
                  send_random_coords(c[2:0], 2'($urandom()));
                  sent++;
               end
            send_random_coords(CMD_COMPUTE,
                               ($urandom_range(99) < 3) ? SHAPE_UNKNOWN :
                               2'($urandom_range(SHAPE_CYLINDER)));
            sent++;
         end else begin
            send_random_coords(3'($urandom()), 2'($urandom()));
            sent++;
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;
      stall_pct = 0;

      // Drain: let the last compute finish and any stray response show up.
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("surface_normal_unit: match");
      else
         $display("surface_normal_unit: mismatch");
      $finish;
   end

endmodule
